@@ rtl/core/assert_macros.svh @@
// assertion helpers shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds on every clock edge outside reset
`define TEL_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition implies result in the following cycle
`define TEL_ASSERT_NEXT(lbl, clk, rst, cond, res, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (res)) else $error(msg);

`endif

@@ rtl/core/tel_pkg.sv @@
// ----------------------------------------------------------------------------
// tel_pkg
// Shared widths, register codes, exp table and job types of the triplet
// exponential loss and gradient block.
// ----------------------------------------------------------------------------
`default_nettype none

package tel_pkg;

  localparam int CHANNELS_DEF = 64;

  localparam int ELEM_W   = 16;
  localparam int WEIGHT_W = 16;
  localparam int DIFF_W   = 17;
  localparam int DIST_W   = 40;
  localparam int CNT_W    = 7;
  localparam int SUM_W    = 48;
  localparam int COEF_W   = 46;
  localparam int GRAD_W   = 32;
  localparam int LOSS_W   = 32;
  localparam int INVB_W   = 17;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int EXP_STEPS  = 12;

  localparam logic [CFG_IDX_W-1:0] REG_MARGIN     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRAD_SCALE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INV_BATCH  = 2'd2;

  localparam logic [31:0]        MARGIN_RST     = 32'd16777216;
  localparam logic [31:0]        GRAD_SCALE_RST = 32'd65536;
  localparam logic [INVB_W-1:0]  INV_BATCH_RST  = 17'd65536;
  localparam logic [INVB_W-1:0]  INV_BATCH_MAX  = 17'd65536;

  localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
  localparam logic [30:0] ONE_Q30   = 31'd1073741824;
  // hinge of 12.0 in q.24 and above saturates the exponential
  localparam logic [40:0] HINGE_SAT = 41'd201326592;

  // 2^(2^-(j+1)) in q1.30
  function automatic logic [30:0] pow2_frac(input logic [3:0] j);
    logic [30:0] v;
    case (j)
      4'd0:    v = 31'd1518500250;
      4'd1:    v = 31'd1276901417;
      4'd2:    v = 31'd1170923762;
      4'd3:    v = 31'd1121280440;
      4'd4:    v = 31'd1097253709;
      4'd5:    v = 31'd1085434107;
      4'd6:    v = 31'd1079572136;
      4'd7:    v = 31'd1076653033;
      4'd8:    v = 31'd1075196444;
      4'd9:    v = 31'd1074468888;
      4'd10:   v = 31'd1074105294;
      4'd11:   v = 31'd1073923544;
      default: v = ONE_Q30;
    endcase
    return v;
  endfunction

  typedef struct packed {
    logic [DIST_W-1:0]   dist_p;
    logic [DIST_W-1:0]   dist_n;
    logic [WEIGHT_W-1:0] weight;
    logic                last_sample;
    logic [CNT_W-1:0]    cnt;
    logic                bank;
  } job_t;

  typedef struct packed {
    logic valid;
    logic bank;
  } release_t;

endpackage

`default_nettype wire

@@ rtl/core/tel_ram.sv @@
// ----------------------------------------------------------------------------
// tel_ram
// Generic simple dual port ram, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module tel_ram #(
  parameter int WIDTH = 34,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/tel_fifo.sv @@
// ----------------------------------------------------------------------------
// tel_fifo
// Two entry queue of finished sample jobs between front and back.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module tel_fifo (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  input  tel_pkg::job_t     push_job,
  input  wire logic         pop,
  output tel_pkg::job_t     head,
  output logic              empty
);

  import tel_pkg::*;

  job_t       slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       full;

  assign empty = (count == 2'd0);
  assign full  = (count == 2'd2);
  assign head  = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_job;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  `TEL_ASSERT(a_no_overflow, clk, rst, !(push && full && !pop), "job queue overflow")
  `TEL_ASSERT(a_no_underflow, clk, rst, !(pop && empty), "job queue underflow")

endmodule

`default_nettype wire

@@ rtl/core/tel_front.sv @@
// ----------------------------------------------------------------------------
// tel_front
// Accepts elements, buffers the differences into the current bank and
// accumulates both squared distances; closes a sample into a job.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module tel_front #(
  parameter int CHANNELS = tel_pkg::CHANNELS_DEF,
  parameter int ADDR_W   = 7
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic signed [tel_pkg::ELEM_W-1:0]   anchor,
  input  wire logic signed [tel_pkg::ELEM_W-1:0]   positive,
  input  wire logic signed [tel_pkg::ELEM_W-1:0]   negative,
  input  wire logic        [tel_pkg::WEIGHT_W-1:0] sample_weight,
  input  wire logic                                last_element,
  input  wire logic                                last_sample,
  output logic                                     wr_en,
  output logic             [ADDR_W-1:0]            wr_addr,
  output logic             [2*tel_pkg::DIFF_W-1:0] wr_data,
  output logic                                     push,
  output tel_pkg::job_t                            push_job,
  input  tel_pkg::release_t                        rel
);

  import tel_pkg::*;

  localparam int IDX_W = ADDR_W - 1;
  localparam int CW    = $clog2(CHANNELS + 1);
  localparam logic [CW-1:0] CH_LIM = CW'(CHANNELS);

  logic [CW-1:0]            count;
  logic [DIST_W-1:0]        acc_p;
  logic [DIST_W-1:0]        acc_n;
  logic                     bank;
  logic [1:0]               busy;
  logic [1:0]               busy_next;
  logic                     accept;
  logic                     room;
  logic signed [DIFF_W-1:0] dap;
  logic signed [DIFF_W-1:0] dan;
  logic [2*DIFF_W-1:0]      sq_p;
  logic [2*DIFF_W-1:0]      sq_n;
  logic [DIST_W-1:0]        acc_p_next;
  logic [DIST_W-1:0]        acc_n_next;
  logic [CW-1:0]            count_next;

  assign in_stall = busy[bank];
  assign accept   = in_valid && !in_stall;
  assign room     = (count < CH_LIM);

  assign dap  = DIFF_W'(anchor) - DIFF_W'(positive);
  assign dan  = DIFF_W'(anchor) - DIFF_W'(negative);
  // full width square, operands widened before the multiply
  assign sq_p = $unsigned((2*DIFF_W)'(dap) * (2*DIFF_W)'(dap));
  assign sq_n = $unsigned((2*DIFF_W)'(dan) * (2*DIFF_W)'(dan));

  // words past the buffer depth only close the sample
  assign acc_p_next = room ? acc_p + DIST_W'(sq_p) : acc_p;
  assign acc_n_next = room ? acc_n + DIST_W'(sq_n) : acc_n;
  assign count_next = room ? count + CW'(1) : count;

  assign wr_en   = accept && room;
  assign wr_addr = {bank, count[IDX_W-1:0]};
  assign wr_data = {dap, dan};

  assign push                 = accept && last_element;
  assign push_job.dist_p      = acc_p_next;
  assign push_job.dist_n      = acc_n_next;
  assign push_job.weight      = sample_weight;
  assign push_job.last_sample = last_sample;
  assign push_job.cnt         = CNT_W'(count_next);
  assign push_job.bank        = bank;

  always_comb begin
    busy_next = busy;
    if (rel.valid) begin
      busy_next[rel.bank] = 1'b0;
    end
    if (push) begin
      busy_next[bank] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      acc_p <= '0;
      acc_n <= '0;
      bank  <= 1'b0;
      busy  <= 2'b00;
    end else begin
      busy <= busy_next;
      if (accept) begin
        if (last_element) begin
          count <= '0;
          acc_p <= '0;
          acc_n <= '0;
          bank  <= ~bank;
        end else begin
          count <= count_next;
          acc_p <= acc_p_next;
          acc_n <= acc_n_next;
        end
      end
    end
  end

  `TEL_ASSERT(a_release_busy, clk, rst, !rel.valid || busy[rel.bank], "release of idle bank")
  `TEL_ASSERT_NEXT(a_push_marks, clk, rst, push, busy[!bank], "pushed bank not marked busy")

endmodule

`default_nettype wire

@@ rtl/core/tel_back.sv @@
// ----------------------------------------------------------------------------
// tel_back
// Takes one sample job at a time: hinge, iterative exp, loss, coefficient and
// batch loss, then streams one gradient word per buffered channel.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module tel_back #(
  parameter int CHANNELS = tel_pkg::CHANNELS_DEF,
  parameter int ADDR_W   = 7
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 job_valid,
  input  tel_pkg::job_t                             job,
  output logic                                      pop,
  input  wire logic        [31:0]                   margin,
  input  wire logic signed [31:0]                   grad_scale,
  input  wire logic        [tel_pkg::INVB_W-1:0]    inv_batch,
  output logic                                      rd_en,
  output logic             [ADDR_W-1:0]             rd_addr,
  input  wire logic        [2*tel_pkg::DIFF_W-1:0]  rd_data,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic signed      [tel_pkg::GRAD_W-1:0]    grad_anchor,
  output logic signed      [tel_pkg::GRAD_W-1:0]    grad_positive,
  output logic signed      [tel_pkg::GRAD_W-1:0]    grad_negative,
  output logic             [tel_pkg::LOSS_W-1:0]    sample_loss,
  output logic             [tel_pkg::LOSS_W-1:0]    batch_loss,
  output logic                                      last_of_run,
  output logic                                      batch_done,
  output tel_pkg::release_t                         rel
);

  import tel_pkg::*;

  localparam int IDX_W = ADDR_W - 1;
  localparam logic signed [56:0] COEF_HI = 57'sd17592186044416;
  localparam logic signed [56:0] COEF_LO = -57'sd17592186044416;

  typedef enum logic [3:0] {
    S_IDLE, S_HINGE, S_LOG, S_EXP, S_SCALE, S_LOSS, S_PROD, S_COEF, S_BATCH,
    S_MUL, S_OUT
  } state_t;

  function automatic logic [GRAD_W-1:0] sat_grad(input logic signed [63:0] p);
    logic signed [63:0] s;
    logic [GRAD_W-1:0]  r;
    s = p >>> 12;
    if (s > 64'sd2147483647) begin
      r = 32'h7FFF_FFFF;
    end else if (s < -64'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = s[31:0];
    end
    return r;
  endfunction

  state_t              state;
  job_t                cur;
  logic [40:0]         hq;
  logic                hsat;
  logic [4:0]          u_k;
  logic [23:0]         u_f;
  logic [30:0]         m;
  logic [3:0]          step;
  logic [31:0]         e;
  logic [LOSS_W-1:0]   loss;
  logic [39:0]         we;
  logic signed [56:0]  p_hi;
  logic signed [48:0]  p_lo;
  logic signed [COEF_W-1:0] coef;
  logic [40:0]         bl_hi;
  logic [40:0]         bl_lo;
  logic [LOSS_W-1:0]   bl;
  logic [SUM_W-1:0]    loss_sum;
  logic [CNT_W-1:0]    idx;
  logic signed [63:0]  prod_a;
  logic signed [63:0]  prod_p;
  logic signed [63:0]  prod_n;

  logic signed [41:0]  t;
  logic [58:0]         uprod;
  logic [61:0]         mprod;
  logic [47:0]         shl;
  logic [33:0]         r;
  logic [47:0]         lprod;
  logic [47:0]         wprod;
  logic [SUM_W:0]      sum;
  logic signed [56:0]  craw;
  logic [INVB_W-1:0]   ib;
  logic [64:0]         blsum;
  logic [48:0]         bq;
  logic signed [DIFF_W-1:0] dap;
  logic signed [DIFF_W-1:0] dan;
  logic signed [17:0]  d_a;
  logic signed [17:0]  d_p;
  logic signed [17:0]  d_n;
  logic                last_run;
  logic                take;
  logic [CNT_W-1:0]    rd_idx;

  assign t     = $signed(42'(margin)) + $signed(42'(cur.dist_p)) - $signed(42'(cur.dist_n));
  assign uprod = hq[27:0] * LOG2E_Q30;
  assign mprod = m * pow2_frac(step);
  assign shl   = 48'(m) << u_k;
  assign r     = shl[47:14];
  assign lprod = cur.weight * (e - 32'd65536);
  assign wprod = cur.weight * e;
  assign sum   = (SUM_W + 1)'(loss_sum) + (SUM_W + 1)'(loss);
  assign craw  = p_hi + 57'(p_lo >>> 16);
  assign ib    = (inv_batch > INV_BATCH_MAX) ? INV_BATCH_MAX : inv_batch;
  assign blsum = {bl_hi, 24'd0} + 65'(bl_lo);
  assign bq    = blsum[64:16];

  assign dap = rd_data[2*DIFF_W-1:DIFF_W];
  assign dan = rd_data[DIFF_W-1:0];
  assign d_a = 18'(dap) - 18'(dan);
  assign d_p = -18'(dap);
  assign d_n = 18'(dan);

  assign last_run = (idx + CNT_W'(1) == cur.cnt);
  assign take     = (state == S_OUT) && !out_stall;
  assign pop      = (state == S_IDLE) && job_valid;

  assign rd_en   = (state == S_BATCH) || (take && !last_run);
  assign rd_idx  = (state == S_BATCH) ? '0 : idx + CNT_W'(1);
  assign rd_addr = {cur.bank, rd_idx[IDX_W-1:0]};

  assign out_valid     = (state == S_OUT);
  assign grad_anchor   = sat_grad(prod_a);
  assign grad_positive = sat_grad(prod_p);
  assign grad_negative = sat_grad(prod_n);
  assign sample_loss   = loss;
  assign batch_loss    = bl;
  assign last_of_run   = last_run;
  assign batch_done    = cur.last_sample;
  assign rel.valid     = take && last_run;
  assign rel.bank      = cur.bank;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      loss_sum <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (job_valid) begin
            cur   <= job;
            state <= S_HINGE;
          end
        end
        S_HINGE: begin
          hq    <= t[41] ? '0 : t[41:1];
          hsat  <= !t[41] && (t[41:1] >= HINGE_SAT);
          state <= S_LOG;
        end
        S_LOG: begin
          u_k   <= uprod[58:54];
          u_f   <= uprod[53:30];
          m     <= ONE_Q30;
          step  <= '0;
          state <= S_EXP;
        end
        S_EXP: begin
          // one fraction bit per cycle, msb first
          if (u_f[5'd23 - {1'b0, step}]) begin
            m <= mprod[60:30];
          end
          if (step == 4'(EXP_STEPS - 1)) begin
            state <= S_SCALE;
          end else begin
            step <= step + 4'd1;
          end
        end
        S_SCALE: begin
          e     <= (hsat || (|r[33:32])) ? 32'hFFFF_FFFF : r[31:0];
          state <= S_LOSS;
        end
        S_LOSS: begin
          if (e > 32'd65536) begin
            loss <= (|lprod[47:40]) ? 32'hFFFF_FFFF : lprod[39:8];
          end else begin
            loss <= '0;
          end
          we    <= wprod[47:8];
          state <= S_PROD;
        end
        S_PROD: begin
          p_hi     <= grad_scale * $signed({1'b0, we[39:16]});
          p_lo     <= grad_scale * $signed({1'b0, we[15:0]});
          loss_sum <= sum[SUM_W] ? '1 : sum[SUM_W-1:0];
          state    <= S_COEF;
        end
        S_COEF: begin
          if (loss == '0) begin
            coef <= '0;
          end else if (craw > COEF_HI) begin
            coef <= COEF_W'(COEF_HI);
          end else if (craw < COEF_LO) begin
            coef <= COEF_W'(COEF_LO);
          end else begin
            coef <= COEF_W'(craw);
          end
          bl_lo <= loss_sum[23:0] * ib;
          bl_hi <= loss_sum[47:24] * ib;
          state <= S_BATCH;
        end
        S_BATCH: begin
          if (cur.last_sample) begin
            bl       <= (|bq[48:32]) ? 32'hFFFF_FFFF : bq[31:0];
            loss_sum <= '0;
          end else begin
            bl <= '0;
          end
          idx   <= '0;
          state <= S_MUL;
        end
        S_MUL: begin
          prod_a <= coef * d_a;
          prod_p <= coef * d_p;
          prod_n <= coef * d_n;
          state  <= S_OUT;
        end
        S_OUT: begin
          if (!out_stall) begin
            if (last_run) begin
              state <= S_IDLE;
            end else begin
              idx   <= idx + CNT_W'(1);
              state <= S_MUL;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `TEL_ASSERT(a_idx_range, clk, rst, (state != S_OUT) || (idx < cur.cnt), "run index past count")
  `TEL_ASSERT_NEXT(a_pop_start, clk, rst, pop, state == S_HINGE, "job pop without start")

endmodule

`default_nettype wire

@@ rtl/core/triplet_exp_loss_grad.sv @@
// ----------------------------------------------------------------------------
// triplet_exp_loss_grad
// Exponential triplet margin loss with per channel gradients, fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): one channel element of anchor,
//   positive and negative plus the sample weight per word; last_element closes
//   the sample, last_sample with it closes the batch.
//   Output channel (out_valid / out_stall): one word per buffered channel,
//   in channel order, carrying three gradients, the sample loss, and on the
//   run that ends a batch the batch loss.
//   Config channel (cfg_valid / cfg_ready): margin, grad_scale, inv_batch;
//   always ready; they are to be written only while the block is idle, a
//   rule for the user that the block does not enforce. Elements are taken
//   one per cycle unless stalled, into one of two difference banks. A
//   closed sample waits in a two entry job queue; the input stalls only
//   when both banks still hold runs not yet delivered. A job passes the
//   hinge, log, twelve step exp, scale, loss, product, coefficient and
//   batch states; each result word then needs a ram read and a gradient
//   multiply, and the next channel starts once a word is taken. A stalled
//   result holds its word; the front keeps filling the other bank. Reset
//   clears accumulators, loss sum, queue, bank flags; sets register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module triplet_exp_loss_grad #(
  parameter int CHANNELS = tel_pkg::CHANNELS_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire logic signed [tel_pkg::ELEM_W-1:0]     anchor,
  input  wire logic signed [tel_pkg::ELEM_W-1:0]     positive,
  input  wire logic signed [tel_pkg::ELEM_W-1:0]     negative,
  input  wire logic        [tel_pkg::WEIGHT_W-1:0]   sample_weight,
  input  wire logic                                  last_element,
  input  wire logic                                  last_sample,
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic signed      [tel_pkg::GRAD_W-1:0]     grad_anchor,
  output logic signed      [tel_pkg::GRAD_W-1:0]     grad_positive,
  output logic signed      [tel_pkg::GRAD_W-1:0]     grad_negative,
  output logic             [tel_pkg::LOSS_W-1:0]     sample_loss,
  output logic             [tel_pkg::LOSS_W-1:0]     batch_loss,
  output logic                                       last_of_run,
  output logic                                       batch_done,
  input  wire logic                                  cfg_valid,
  output logic                                       cfg_ready,
  input  wire logic        [tel_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic        [tel_pkg::CFG_DATA_W-1:0] cfg_data
);

  import tel_pkg::*;

  localparam int IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int ADDR_W = IDX_W + 1;
  localparam int DEPTH  = 2 ** ADDR_W;

  logic [31:0]         margin;
  logic signed [31:0]  grad_scale;
  logic [INVB_W-1:0]   inv_batch;

  logic                wr_en;
  logic [ADDR_W-1:0]   wr_addr;
  logic [2*DIFF_W-1:0] wr_data;
  logic                rd_en;
  logic [ADDR_W-1:0]   rd_addr;
  logic [2*DIFF_W-1:0] rd_data;
  logic                push;
  job_t                push_job;
  job_t                head;
  logic                empty;
  logic                pop;
  release_t            rel;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      margin     <= MARGIN_RST;
      grad_scale <= $signed(GRAD_SCALE_RST);
      inv_batch  <= INV_BATCH_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MARGIN:     margin     <= cfg_data;
        REG_GRAD_SCALE: grad_scale <= $signed(cfg_data);
        REG_INV_BATCH:  inv_batch  <= cfg_data[INVB_W-1:0];
        default: ;
      endcase
    end
  end

  tel_front #(
    .CHANNELS (CHANNELS),
    .ADDR_W   (ADDR_W)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .anchor        (anchor),
    .positive      (positive),
    .negative      (negative),
    .sample_weight (sample_weight),
    .last_element  (last_element),
    .last_sample   (last_sample),
    .wr_en         (wr_en),
    .wr_addr       (wr_addr),
    .wr_data       (wr_data),
    .push          (push),
    .push_job      (push_job),
    .rel           (rel)
  );

  tel_ram #(
    .WIDTH (2 * DIFF_W),
    .DEPTH (DEPTH)
  ) u_diff_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  tel_fifo u_jobs (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .empty    (empty)
  );

  tel_back #(
    .CHANNELS (CHANNELS),
    .ADDR_W   (ADDR_W)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .job_valid     (!empty),
    .job           (head),
    .pop           (pop),
    .margin        (margin),
    .grad_scale    (grad_scale),
    .inv_batch     (inv_batch),
    .rd_en         (rd_en),
    .rd_addr       (rd_addr),
    .rd_data       (rd_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .grad_anchor   (grad_anchor),
    .grad_positive (grad_positive),
    .grad_negative (grad_negative),
    .sample_loss   (sample_loss),
    .batch_loss    (batch_loss),
    .last_of_run   (last_of_run),
    .batch_done    (batch_done),
    .rel           (rel)
  );

endmodule

`default_nettype wire

@@ sim/tel_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tel_checker
// Watches the element, result and register channels of the triplet loss
// block, predicts every result word and compares it field by field.
// ----------------------------------------------------------------------------
module tel_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic signed [15:0] anchor,
  input  logic signed [15:0] positive,
  input  logic signed [15:0] negative,
  input  logic [15:0]        sample_weight,
  input  logic               last_element,
  input  logic               last_sample,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [31:0] grad_anchor,
  input  logic signed [31:0] grad_positive,
  input  logic signed [31:0] grad_negative,
  input  logic [31:0]        sample_loss,
  input  logic [31:0]        batch_loss,
  input  logic               last_of_run,
  input  logic               batch_done,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  output int                 fail_count,
  output int                 pending,
  output int                 words_seen,
  output int                 runs_seen
);
  import tel_pkg::*;

  typedef struct packed {
    logic signed [31:0] ga;
    logic signed [31:0] gp;
    logic signed [31:0] gn;
    logic [31:0]        loss;
    logic [31:0]        bloss;
    logic               last;
    logic               done;
  } grad_word_t;

  grad_word_t expected_words[$];

  logic [31:0] margin_q;
  logic signed [31:0] scale_q;
  logic [16:0] invb_q;
  longint dap_buf[64];
  longint dan_buf[64];
  longint dist_p, dist_n, loss_sum;
  int elem_cnt;

  function automatic longint floor_sh(longint x, int s);
    return x >>> s;
  endfunction

  function automatic longint clampv(longint x, longint lo, longint hi);
    return x < lo ? lo : (x > hi ? hi : x);
  endfunction

  function automatic longint exp_fixed(longint h);
    logic [63:0] u, f, m, r;
    int k;
    if (h >= (64'd12 << 24)) return 64'hFFFFFFFF;
    u = (64'(h) * 64'(LOG2E_Q30)) >> 30;
    k = int'(u >> 24);
    f = u & 64'hFFFFFF;
    m = 64'(ONE_Q30);
    for (int j = 0; j < 12; j++)
      if (f[23-j]) m = (m * 64'(pow2_frac(4'(j)))) >> 30;
    r = (m << k) >> 14;
    return r > 64'hFFFFFFFF ? 64'hFFFFFFFF : longint'(r);
  endfunction

  task automatic report(string what, grad_word_t got, grad_word_t want);
    $display("tb: mismatch on %s: got %h want %h", what, got, want);
    fail_count++;
  endtask

  task automatic predict_element();
    longint dap, dan, t, h, e, loss, coef, we, bl, wv;
    grad_word_t wd;
    if (elem_cnt < 64) begin
      dap = longint'(anchor) - longint'(positive);
      dan = longint'(anchor) - longint'(negative);
      dap_buf[elem_cnt] = dap;
      dan_buf[elem_cnt] = dan;
      dist_p += dap * dap;
      dist_n += dan * dan;
      elem_cnt++;
    end
    if (!last_element) return;
    wv = longint'(sample_weight);
    t = longint'(margin_q) + dist_p - dist_n;
    h = t > 0 ? t >>> 1 : 0;
    e = exp_fixed(h);
    loss = e > 65536 ? (wv * (e - 65536)) >>> 8 : 0;
    if (loss > 64'hFFFFFFFF) loss = 64'hFFFFFFFF;
    loss_sum += loss;
    if (loss_sum > 64'hFFFFFFFFFFFF) loss_sum = 64'hFFFFFFFFFFFF;
    coef = 0;
    if (loss != 0) begin
      we = (wv * e) >>> 8;
      coef = longint'(scale_q) * (we >>> 16) + floor_sh(longint'(scale_q) * (we & 16'hFFFF), 16);
      coef = clampv(coef, -64'sd17592186044416, 64'sd17592186044416);
    end
    bl = 0;
    if (last_sample) begin
      bl = (loss_sum * longint'(invb_q > 17'd65536 ? 17'd65536 : invb_q)) >>> 16;
      if (bl > 64'hFFFFFFFF) bl = 64'hFFFFFFFF;
      loss_sum = 0;
    end
    for (int i = 0; i < elem_cnt; i++) begin
      wd.ga = 32'(clampv(floor_sh(coef * (dap_buf[i] - dan_buf[i]), 12), -(64'sd1 << 31),
                         (64'sd1 << 31) - 1));
      wd.gp = 32'(clampv(floor_sh(coef * -dap_buf[i], 12), -(64'sd1 << 31), (64'sd1 << 31) - 1));
      wd.gn = 32'(clampv(floor_sh(coef * dan_buf[i], 12), -(64'sd1 << 31), (64'sd1 << 31) - 1));
      wd.loss = 32'(loss);
      wd.bloss = 32'(bl);
      wd.last = (i + 1 == elem_cnt);
      wd.done = last_sample;
      expected_words.push_back(wd);
    end
    dist_p = 0;
    dist_n = 0;
    elem_cnt = 0;
  endtask

  always @(posedge clk) begin
    grad_word_t got, want;
    if (rst) begin
      margin_q <= MARGIN_RST;
      scale_q <= GRAD_SCALE_RST;
      invb_q <= INV_BATCH_RST;
      dist_p = 0;
      dist_n = 0;
      loss_sum = 0;
      elem_cnt = 0;
      fail_count = 0;
      words_seen = 0;
      runs_seen = 0;
      expected_words.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MARGIN:     margin_q <= cfg_data;
          REG_GRAD_SCALE: scale_q <= cfg_data;
          REG_INV_BATCH:  invb_q <= cfg_data[16:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) predict_element();
      if (out_valid && !out_stall) begin
        got = '{grad_anchor, grad_positive, grad_negative, sample_loss, batch_loss,
                last_of_run, batch_done};
        words_seen++;
        if (last_of_run) runs_seen++;
        if (expected_words.size() == 0) begin
          report("unexpected word", got, got);
        end else begin
          want = expected_words.pop_front();
          if (got.ga !== want.ga) report("grad_anchor", got, want);
          if (got.gp !== want.gp) report("grad_positive", got, want);
          if (got.gn !== want.gn) report("grad_negative", got, want);
          if (got.loss !== want.loss) report("sample_loss", got, want);
          if (got.bloss !== want.bloss) report("batch_loss", got, want);
          if (got.last !== want.last) report("last_of_run", got, want);
          if (got.done !== want.done) report("batch_done", got, want);
        end
      end
    end
    pending = expected_words.size();
  end
endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the triplet loss block: directed corner samples, then random
// batches under several register settings with bursty input and output stalls.
// ----------------------------------------------------------------------------
module tb_top;
  import tel_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [15:0] anchor = '0, positive = '0, negative = '0;
  logic [15:0] sample_weight = '0;
  logic last_element = 1'b0, last_sample = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] grad_anchor, grad_positive, grad_negative;
  logic [31:0] sample_loss, batch_loss;
  logic last_of_run, batch_done;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  int fail_count, pending, words_seen, runs_seen;
  int items_sent = 0;
  int burst_left = 0;
  int stall_mode = 0;

  always #4 clk = ~clk;

  triplet_exp_loss_grad DUT (.*);

  tel_checker checker_i (.*);

  // receiver stall pattern, changes its mode now and then
  always @(negedge clk) begin
    if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 1) == 0);
      default: out_stall <= ($urandom_range(0, 9) != 0);
    endcase
  end

  // valid stays high across a burst and drops only for a gap
  task automatic send_elem(logic signed [15:0] a, logic signed [15:0] p, logic signed [15:0] n,
                           logic [15:0] w, logic le, logic ls);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 1) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    in_valid <= 1'b1;
    anchor <= a;
    positive <= p;
    negative <= n;
    sample_weight <= w;
    last_element <= le;
    last_sample <= ls;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  function automatic logic signed [15:0] rnd_elem();
    case ($urandom_range(0, 3))
      0: return 16'($urandom);
      1: return 16'sh7FFF;
      2: return -16'sh8000;
      default: return 16'($signed($urandom_range(0, 1023)) - 512);
    endcase
  endfunction

  task automatic random_sample(int len, logic ls);
    logic [15:0] w;
    w = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'd256;
    for (int i = 0; i < len; i++)
      send_elem(rnd_elem(), rnd_elem(), rnd_elem(), w, i == len - 1,
                (i == len - 1) ? ls : 1'($urandom_range(0, 1)));
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    // directed: zero hinge, large hinge, extremes, single element
    send_elem(16'sh0, 16'sh0, 16'sh0, 16'd256, 1'b1, 1'b0);
    send_elem(16'sh7FFF, -16'sh8000, 16'sh7FFF, 16'hFFFF, 1'b0, 1'b1);
    send_elem(-16'sh8000, 16'sh7FFF, -16'sh8000, 16'hFFFF, 1'b1, 1'b0);
    send_elem(16'sh1000, 16'sh0800, -16'sh1000, 16'd0, 1'b1, 1'b0);
    send_elem(16'sh1000, 16'sh1000, 16'sh1000, 16'd256, 1'b1, 1'b1);
    // overfull sample beyond the buffer depth
    for (int i = 0; i < 70; i++)
      send_elem(16'sh0100, 16'sh0, 16'sh0080, 16'd512, i == 69, i == 69);
    drain();
    write_reg(REG_MARGIN, 32'hFFFFFFFF);
    write_reg(REG_GRAD_SCALE, 32'h7FFFFFFF);
    write_reg(REG_INV_BATCH, 32'h1FFFF);
    for (int s = 0; s < 4; s++) random_sample($urandom_range(1, 4), s == 3);
    drain();
    for (int ph = 0; ph < 5; ph++) begin
      write_reg(REG_MARGIN, ph == 0 ? 32'd0 : $urandom);
      write_reg(REG_GRAD_SCALE, ph == 1 ? 32'h80000000 : $urandom);
      write_reg(REG_INV_BATCH, ph == 2 ? 32'd0 : $urandom_range(0, 65536));
      for (int s = 0; s < 10; s++)
        random_sample($urandom_range(0, 7) == 0 ? $urandom_range(30, 64) : $urandom_range(1, 3),
                      $urandom_range(0, 3) == 0);
      drain();
    end
    $display("tb: %0d elements driven, %0d result words in %0d runs checked",
             items_sent, words_seen, runs_seen);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end
endmodule

@@ triplet_exp_loss_grad.f @@
+incdir+rtl/core
rtl/core/tel_pkg.sv
rtl/core/tel_ram.sv
rtl/core/tel_fifo.sv
rtl/core/tel_front.sv
rtl/core/tel_back.sv
rtl/core/triplet_exp_loss_grad.sv
sim/tel_checker.sv
sim/tb_top.sv
